// File: rtl/core/tanh_waveshaper_core_defines.svh
// ----------------------------------------------------------------------------
// Tanh waveshaper: assertion macros
// Shared assertion wrappers, clocked on clk; only TWS_ASSERT is disabled by arst_n.
// ----------------------------------------------------------------------------
`ifndef TANH_WAVESHAPER_CORE_DEFINES_SVH
`define TANH_WAVESHAPER_CORE_DEFINES_SVH

// Check a property outside reset
`define TWS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define TWS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/tws_pkg.sv
// ----------------------------------------------------------------------------
// Tanh waveshaper package
// Widths, register codes and the constant tanh node table.
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

	// Sample and table geometry
	localparam int SAMPLE_BITS    = 16;
	localparam int TABLE_SEGMENTS = 256;
	localparam int FRAC_BITS      = SAMPLE_BITS - 1;
	localparam int ARG_BITS       = 16;
	localparam int ARG_FRAC       = 12;
	localparam int TBL_FRAC       = 24;
	localparam int EXP_FRAC       = 31;
	localparam int U_LIMIT_BITS   = 14;
	localparam int IDX_W          = $clog2(TABLE_SEGMENTS + 1);
	localparam int POS_W          = U_LIMIT_BITS + IDX_W;
	localparam int NODE_W         = TBL_FRAC + 1;
	localparam int TANH_W         = NODE_W + 1;
	localparam int PROD1_W        = ARG_BITS + SAMPLE_BITS;
	localparam int PROD2_W        = ARG_BITS + TANH_W;
	localparam int OUT_SHIFT      = ARG_FRAC + TBL_FRAC - FRAC_BITS;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic signed [ARG_BITS-1:0] CFG_UNITY = ARG_BITS'(4096);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOPE = 2'd0,
		REG_GAIN  = 2'd1
	} cfg_reg_t;

	typedef logic [TABLE_SEGMENTS:0][NODE_W-1:0] tanh_tbl_t;

	// Restoring division, used only while building the table at elaboration
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] rem;
		int          b;
		q   = '0;
		rem = '0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Nodes tanh(4k/N) in Q.24 from integer powers of exp(-8/N)
	function automatic tanh_tbl_t build_tanh_tbl();
		logic [63:0] term;
		logic [63:0] r;
		logic [63:0] n;
		logic [63:0] e;
		logic [63:0] one;
		logic [63:0] den;
		logic [63:0] num;
		logic        neg;
		tanh_tbl_t   tbl;
		int          k;
		one  = 64'd1 << EXP_FRAC;
		term = one;
		r    = one;
		n    = 64'd1;
		neg  = 1'b0;
		e    = one;
		tbl  = '0;
		while (term != 64'd0) begin
			term = udiv64(term * 64'd8, 64'(TABLE_SEGMENTS) * n);
			n    = n + 64'd1;
			neg  = !neg;
			if (neg) begin
				r = r - term;
			end else begin
				r = r + term;
			end
		end
		for (k = 0; k <= TABLE_SEGMENTS; k++) begin
			den    = one + e;
			num    = (one - e) << TBL_FRAC;
			tbl[k] = NODE_W'(udiv64(num + (den >> 1), den));
			e      = (e * r + (64'd1 << (EXP_FRAC - 1))) >> EXP_FRAC;
		end
		return tbl;
	endfunction

	localparam tanh_tbl_t TANH_TBL = build_tanh_tbl();

endpackage

`default_nettype wire

// File: rtl/core/tws_ifs.sv
// ----------------------------------------------------------------------------
// Tanh waveshaper channel interfaces
// Sample input, shaped output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tws_in_if
	import tws_pkg::*;
();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          block_end_in;

	modport source (output valid, output sample_in, output block_end_in, input ready);
	modport sink   (input valid, input sample_in, input block_end_in, output ready);
endinterface

interface tws_out_if
	import tws_pkg::*;
();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          clipped;
	logic                          block_end_out;

	modport source (output valid, output sample_out, output clipped, output block_end_out,
		input ready);
	modport sink   (input valid, input sample_out, input clipped, input block_end_out,
		output ready);
endinterface

interface tws_cfg_if
	import tws_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [ARG_BITS-1:0]  wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tanh_waveshaper_core.sv
// ----------------------------------------------------------------------------
// Tanh waveshaper core
// Soft-clipper giving gain * tanh(slope * x) per Q1.15 sample.
// ----------------------------------------------------------------------------
// Takes one sample per clock unless dout stalls; each result follows its
// transaction on din, in order, one result per sample. The six register stages
// are: slope multiply, argument rounding and table addressing, node lookup,
// interpolation multiply, gain multiply, output rounding and saturation. The
// whole pipeline advances together, so din.ready follows dout.ready whenever
// the last stage holds a result; a stall holds every stage. The register port
// is always ready; write slope and gain only while no sample is in flight.
`default_nettype none
`include "tanh_waveshaper_core_defines.svh"

module tanh_waveshaper_core
	import tws_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	tws_in_if.sink    din,
	tws_out_if.source dout,
	tws_cfg_if.sink   cfg
);

	localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [TANH_W-1:0]      T_ONE   = TANH_W'(1) <<< TBL_FRAC;
	localparam logic [NODE_W-1:0]             N_ONE   = NODE_W'(1) << TBL_FRAC;

	// Configuration registers
	logic signed [ARG_BITS-1:0] slope_q;
	logic signed [ARG_BITS-1:0] gain_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_q <= CFG_UNITY;
			gain_q  <= CFG_UNITY;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SLOPE: slope_q <= cfg.wdata;
				REG_GAIN:  gain_q  <= cfg.wdata;
				default:   ;
			endcase
		end
	end

	// Pipeline advance: move every stage when the last one is empty or taken
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign adv       = !v_s6 || dout.ready;
	assign din.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= din.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: slope times sample
	logic signed [PROD1_W-1:0] p_s1;
	logic                      be_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1  <= slope_q * din.sample_in;
			be_s1 <= din.block_end_in;
		end
	end

	// Stage 2: round to Q4.12, saturate, fold sign, find segment and fraction
	logic signed [PROD1_W:0]   u_rnd;
	logic signed [PROD1_W:0]   u_sh;
	logic signed [ARG_BITS-1:0] u_sat;
	logic [ARG_BITS-1:0]       m;
	logic [POS_W-1:0]          pos;
	logic                      neg_s2, big_s2, be_s2;
	logic [IDX_W-1:0]          idx_s2;
	logic [U_LIMIT_BITS-1:0]   frac_s2;

	always_comb begin
		u_rnd = {p_s1[PROD1_W-1], p_s1} + ((PROD1_W + 1)'(1) << (FRAC_BITS - 1));
		u_sh  = u_rnd >>> FRAC_BITS;
		if (&u_sh[PROD1_W:ARG_BITS-1] || !(|u_sh[PROD1_W:ARG_BITS-1])) begin
			u_sat = u_sh[ARG_BITS-1:0];
		end else if (u_sh[PROD1_W]) begin
			u_sat = {1'b1, {(ARG_BITS-1){1'b0}}};
		end else begin
			u_sat = {1'b0, {(ARG_BITS-1){1'b1}}};
		end
		m   = u_sat[ARG_BITS-1] ? ARG_BITS'(-u_sat) : ARG_BITS'(u_sat);
		pos = POS_W'(m[U_LIMIT_BITS-1:0]) * POS_W'(TABLE_SEGMENTS);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2  <= u_sat[ARG_BITS-1];
			big_s2  <= |m[ARG_BITS-1:U_LIMIT_BITS];
			idx_s2  <= pos[POS_W-1:U_LIMIT_BITS];
			frac_s2 <= pos[U_LIMIT_BITS-1:0];
			be_s2   <= be_s1;
		end
	end

	// Stage 3: read the two bounding nodes
	logic [NODE_W-1:0]       lo, hi;
	logic [NODE_W-1:0]       lo_s3, d_s3;
	logic [U_LIMIT_BITS-1:0] frac_s3;
	logic                    neg_s3, big_s3, be_s3;

	always_comb begin
		lo = TANH_TBL[idx_s2];
		hi = TANH_TBL[IDX_W'(idx_s2 + 1'b1)];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s3   <= lo;
			d_s3    <= (hi >= lo) ? hi - lo : '0;
			frac_s3 <= frac_s2;
			neg_s3  <= neg_s2;
			big_s3  <= big_s2;
			be_s3   <= be_s2;
		end
	end

	// Stage 4: interpolate, or take one beyond the table, and restore the sign
	logic [NODE_W+U_LIMIT_BITS-1:0] df;
	logic [NODE_W-1:0]              tm;
	logic signed [TANH_W-1:0]       t_s4;
	logic                           be_s4;

	always_comb begin
		df = d_s3 * frac_s3;
		tm = big_s3 ? N_ONE : lo_s3 + df[NODE_W+U_LIMIT_BITS-1:U_LIMIT_BITS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s4  <= neg_s3 ? -$signed({1'b0, tm}) : $signed({1'b0, tm});
			be_s4 <= be_s3;
		end
	end

	// Stage 5: gain times tanh
	logic signed [PROD2_W-1:0] y_s5;
	logic                      be_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s5  <= gain_q * t_s4;
			be_s5 <= be_s4;
		end
	end

	// Stage 6: round to Q1.15 and saturate
	logic signed [PROD2_W:0]        y_rnd;
	logic signed [PROD2_W:0]        y_sh;
	logic signed [SAMPLE_BITS-1:0]  y_sat;
	logic                           clip;
	logic signed [SAMPLE_BITS-1:0]  y_s6;
	logic                           clip_s6, be_s6;

	always_comb begin
		y_rnd = {y_s5[PROD2_W-1], y_s5} + ((PROD2_W + 1)'(1) << (OUT_SHIFT - 1));
		y_sh  = y_rnd >>> OUT_SHIFT;
		clip  = 1'b0;
		if (&y_sh[PROD2_W:SAMPLE_BITS-1] || !(|y_sh[PROD2_W:SAMPLE_BITS-1])) begin
			y_sat = y_sh[SAMPLE_BITS-1:0];
		end else begin
			y_sat = y_sh[PROD2_W] ? OUT_MIN : OUT_MAX;
			clip  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s6    <= y_sat;
			clip_s6 <= clip;
			be_s6   <= be_s5;
		end
	end

	assign dout.valid         = v_s6;
	assign dout.sample_out    = y_s6;
	assign dout.clipped       = clip_s6;
	assign dout.block_end_out = be_s6;

	// Assertions
	`TWS_ASSERT(a_clip_at_rail, dout.valid && dout.clipped |-> (dout.sample_out == OUT_MAX || dout.sample_out == OUT_MIN), "clipped result not at a rail")
	`TWS_ASSERT(a_tanh_bound, v_s4 |-> (t_s4 <= T_ONE && t_s4 >= -T_ONE), "tanh value beyond unity")
	`TWS_ASSERT(a_last_advance, adv |=> (v_s6 == $past(v_s5)), "last stage did not take its predecessor")
	`TWS_ASSERT_ALWAYS(a_cfg_ready, cfg.ready, "register port not ready")

endmodule

`default_nettype wire

// File: tb/tanh_waveshaper_core_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tanh waveshaper shaping monitor
// Watches the register, sample and result channels. Computes each shaped
// sample from the current slope and gain and compares it with the core's
// output in order.
// ----------------------------------------------------------------------------

module tanh_waveshaper_core_chk
	import tws_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tws_in_if    din,
	tws_out_if   dout,
	tws_cfg_if   cfg,
	output int   n_pending,
	output int   n_fail
);

	localparam int  OUT_SH    = ARG_FRAC + TBL_FRAC - FRAC_BITS;
	localparam longint ARG_MAX   = (longint'(1) << (ARG_BITS - 1)) - 1;
	localparam longint ARG_MIN   = -(longint'(1) << (ARG_BITS - 1));
	localparam longint ARG_SPAN  = longint'(1) << U_LIMIT_BITS;
	localparam longint TANH_ONE  = longint'(1) << TBL_FRAC;
	localparam longint SMP_MAX   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint SMP_MIN   = -(longint'(1) << (SAMPLE_BITS - 1));

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          clipped;
		logic                          block_end;
	} shaped_t;

	longint                     tanh_node [TABLE_SEGMENTS+1];
	logic signed [ARG_BITS-1:0] slope_r;
	logic signed [ARG_BITS-1:0] gain_r;
	shaped_t                    shaped_q [$];

	// Derive the tanh nodes from integer powers of exp(-8/N)
	function automatic void build_nodes();
		longint unsigned unit;
		longint unsigned term;
		longint unsigned ratio;
		longint unsigned step;
		longint unsigned pw;
		longint unsigned den;
		longint unsigned num;
		bit              alt;
		unit  = 64'd1 << EXP_FRAC;
		term  = unit;
		ratio = unit;
		step  = 64'd1;
		alt   = 1'b0;
		pw    = unit;
		// truncated alternating series for the step ratio
		while (term != 64'd0) begin
			term = (term * 64'd8) / (64'(TABLE_SEGMENTS) * step);
			step = step + 64'd1;
			alt  = !alt;
			if (alt) begin
				ratio = ratio - term;
			end else begin
				ratio = ratio + term;
			end
		end
		for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
			den          = unit + pw;
			num          = (unit - pw) << TBL_FRAC;
			tanh_node[k] = longint'((num + den / 64'd2) / den);
			pw           = (pw * ratio + (64'd1 << (EXP_FRAC - 1))) >> EXP_FRAC;
		end
	endfunction

	initial build_nodes();

	// Shape one sample with the current slope and gain
	function automatic shaped_t shape(logic signed [SAMPLE_BITS-1:0] x, logic be);
		longint  arg;
		longint  mag;
		longint  pos;
		longint  seg;
		longint  frac;
		longint  lo;
		longint  hi;
		longint  diff;
		longint  tmag;
		longint  th;
		longint  y;
		shaped_t r;
		arg = (longint'(slope_r) * longint'(x) + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (arg > ARG_MAX) arg = ARG_MAX;
		if (arg < ARG_MIN) arg = ARG_MIN;
		mag = (arg < 0) ? -arg : arg;
		// flat at one beyond the table, interpolate inside it
		if (mag >= ARG_SPAN) begin
			tmag = TANH_ONE;
		end else begin
			pos  = mag * TABLE_SEGMENTS;
			seg  = pos / ARG_SPAN;
			frac = pos % ARG_SPAN;
			lo   = tanh_node[seg];
			hi   = tanh_node[seg+1];
			diff = (hi >= lo) ? hi - lo : 0;
			tmag = lo + (diff * frac) / ARG_SPAN;
		end
		th = (arg < 0) ? -tmag : tmag;
		y  = (longint'(gain_r) * th + (longint'(1) << (OUT_SH - 1))) >>> OUT_SH;
		r.clipped = 1'b0;
		if (y > SMP_MAX) begin
			y         = SMP_MAX;
			r.clipped = 1'b1;
		end else if (y < SMP_MIN) begin
			y         = SMP_MIN;
			r.clipped = 1'b1;
		end
		r.sample    = y[SAMPLE_BITS-1:0];
		r.block_end = be;
		return r;
	endfunction

	// Track register writes, queue expected samples, compare results
	always @(posedge clk or negedge arst_n) begin
		shaped_t want;
		if (!arst_n) begin
			slope_r = CFG_UNITY;
			gain_r  = CFG_UNITY;
			shaped_q.delete();
			n_fail  = 0;
		end else begin
			if (dout.valid && dout.ready) begin
				if (shaped_q.size() == 0) begin
					$display("%0t: result with none outstanding: sample_out %0d clipped %0b block_end %0b",
						$time, dout.sample_out, dout.clipped, dout.block_end_out);
					n_fail++;
				end else begin
					want = shaped_q.pop_front();
					if (dout.sample_out !== want.sample) begin
						$display("%0t: sample_out expected %0d actual %0d", $time, want.sample,
							dout.sample_out);
						n_fail++;
					end
					if (dout.clipped !== want.clipped) begin
						$display("%0t: clipped expected %0b actual %0b", $time, want.clipped,
							dout.clipped);
						n_fail++;
					end
					if (dout.block_end_out !== want.block_end) begin
						$display("%0t: block_end_out expected %0b actual %0b", $time,
							want.block_end, dout.block_end_out);
						n_fail++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_SLOPE) slope_r = cfg.wdata;
				else if (cfg.index == REG_GAIN) gain_r = cfg.wdata;
			end
			if (din.valid && din.ready)
				shaped_q.push_back(shape(din.sample_in, din.block_end_in));
		end
		n_pending = shaped_q.size();
	end

endmodule

// File: tb/tanh_waveshaper_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tanh waveshaper core testbench
// Drives directed and random samples through the core under several slope
// and gain settings and idling patterns; the shaping monitor checks results.
// ----------------------------------------------------------------------------

module tanh_waveshaper_core_tb;
	import tws_pkg::*;

	localparam int PIPE_DEPTH   = 6;
	localparam int DRAIN_CYCLES = 4 * PIPE_DEPTH;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 210;

	logic clk;
	logic arst_n;
	int   src_idle_pct  = 0;
	int   snk_stall_pct = 0;
	int   n_pending;
	int   n_fail;

	tws_in_if  din_if ();
	tws_out_if dout_if ();
	tws_cfg_if cfg_if ();

	tanh_waveshaper_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if),
		.cfg    (cfg_if)
	);

	tanh_waveshaper_core_chk shape_mon (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din_if),
		.dout      (dout_if),
		.cfg       (cfg_if),
		.n_pending (n_pending),
		.n_fail    (n_fail)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		dout_if.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// Hold the sample channel idle for a random gap
	task automatic idle_gap();
		while ($urandom_range(99) < src_idle_pct) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Offer one sample and return at the edge that takes it
	task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic be);
		idle_gap();
		din_if.valid        <= 1'b1;
		din_if.sample_in    <= s;
		din_if.block_end_in <= be;
		@(negedge clk);
		while (!din_if.ready) @(negedge clk);
		@(posedge clk);
	endtask

	// Drop valid and wait for every outstanding result, then let the pipe empty
	task automatic settle();
		din_if.valid <= 1'b0;
		do @(negedge clk); while (n_pending != 0);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	// Write one register once the core is idle
	task automatic write_reg(input cfg_reg_t idx, input logic signed [ARG_BITS-1:0] v);
		settle();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.wdata <= v;
		@(negedge clk);
		while (!cfg_if.ready) @(negedge clk);
		@(posedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic set_coefs(input logic signed [ARG_BITS-1:0] sl,
		input logic signed [ARG_BITS-1:0] gn);
		write_reg(REG_SLOPE, sl);
		write_reg(REG_GAIN, gn);
	endtask

	// Mostly full-range samples, with small values and full scale mixed in
	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		logic signed [SAMPLE_BITS-1:0] s;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
					1: s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
					2: s = '0;
					3: s = '1;
					default: s = SAMPLE_BITS'(1);
				endcase
			end
			1, 2: begin
				s = SAMPLE_BITS'($urandom_range(511));
				if ($urandom_range(1)) s = -s;
			end
			default: s = SAMPLE_BITS'($urandom);
		endcase
		return s;
	endfunction

	// Coefficients: extremes, unity, moderate and full-range values
	function automatic logic signed [ARG_BITS-1:0] rand_coef();
		logic signed [ARG_BITS-1:0] c;
		case ($urandom_range(5))
			0: c = {1'b1, {(ARG_BITS-1){1'b0}}};
			1: c = {1'b0, {(ARG_BITS-1){1'b1}}};
			2: c = CFG_UNITY;
			3, 4: begin
				c = ARG_BITS'($urandom_range(20000));
				if ($urandom_range(1)) c = -c;
			end
			default: c = ARG_BITS'($urandom);
		endcase
		return c;
	endfunction

	// Stimulus
	initial begin
		din_if.valid        = 1'b0;
		din_if.sample_in    = '0;
		din_if.block_end_in = 1'b0;
		cfg_if.valid        = 1'b0;
		cfg_if.index        = REG_SLOPE;
		cfg_if.wdata        = '0;
		dout_if.ready       = 1'b0;
		arst_n              = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Unity slope and gain straight out of reset
		push_sample(16'sd0, 1'b0);
		push_sample(16'sd32767, 1'b1);
		push_sample(-16'sd32768, 1'b0);
		push_sample(16'sd1, 1'b1);
		push_sample(-16'sd1, 1'b0);
		push_sample(16'sd16384, 1'b0);
		push_sample(-16'sd16384, 1'b1);
		push_sample(16'sh5555, 1'b0);

		// Steep slope: full-scale tanh with unity gain saturates
		set_coefs(16'sd32767, CFG_UNITY);
		push_sample(16'sd32767, 1'b0);
		push_sample(-16'sd32768, 1'b1);
		push_sample(16'sd2000, 1'b0);
		push_sample(16'sd512, 1'b0);

		// Most negative slope and gain: argument overflow, mirrored output
		set_coefs(-16'sd32768, -16'sd32768);
		push_sample(-16'sd32768, 1'b1);
		push_sample(16'sd32767, 1'b0);
		push_sample(16'sd100, 1'b0);
		push_sample(-16'sd100, 1'b1);

		// Argument inside the table and at its upper edge
		set_coefs(16'sd16384, 16'sd32767);
		push_sample(16'sd8192, 1'b0);
		push_sample(16'sd32767, 1'b0);
		push_sample(-16'sd1, 1'b1);
		push_sample(16'sd0, 1'b0);

		// Zero slope
		set_coefs(16'sd0, -16'sd32768);
		push_sample(16'sd12345, 1'b0);
		push_sample(-16'sd32768, 1'b1);

		// Random phases, each with its own coefficients and idling pattern
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_coefs(CFG_UNITY, CFG_UNITY);
				1: set_coefs(16'sd32767, -16'sd32768);
				2: set_coefs(-16'sd32768, 16'sd32767);
				default: set_coefs(rand_coef(), rand_coef());
			endcase
			case (p % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 62; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 62; end
				default: begin src_idle_pct = 29; snk_stall_pct = 29; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// now and then hold off until the core has drained
				if ($urandom_range(99) == 0) settle();
				push_sample(rand_sample(), ($urandom_range(7) == 0));
			end
		end

		// Drain and give the verdict
		din_if.valid <= 1'b0;
		do @(negedge clk); while (n_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/tws_pkg.sv
rtl/core/tws_ifs.sv
rtl/core/tanh_waveshaper_core.sv
tb/tanh_waveshaper_core_chk.sv
tb/tanh_waveshaper_core_tb.sv
